/* design/imm_pkg.sv */
// Shared constants, types and helpers for the integer matrix multiplier.
package imm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;
  localparam int DIM_W      = 4;
  localparam int IDX_W      = 3;
  localparam int ADDR_W     = 6;
  localparam int CNT_W      = 7;
  localparam int MUL_W      = 2 * ELEM_WIDTH;
  localparam int PROD_W     = 36;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  localparam logic MODE_A = 1'b0;
  localparam logic MODE_B = 1'b1;

  typedef enum logic [1:0] {
    STAT_PRODUCT  = 2'd0,
    STAT_MISMATCH = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  // Control into the multiply-accumulate unit.
  typedef struct packed {
    logic valid;  // operand data present this cycle
    logic last;   // operand pair closes the dot product
    logic clear;  // zero the accumulator
  } mac_ctl_t;

  // Clamp a dimension register into 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) res = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) res = DIM_W'(MAX_DIM);
    else res = v;
    return res;
  endfunction

endpackage

/* design/imm_if.sv */
// Valid/ready channel interfaces for the input elements and the result items.
interface imm_in_if import imm_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [ELEM_WIDTH-1:0] element;

  modport source(output valid, output mode, output element, input ready);
  modport sink(input valid, input mode, input element, output ready);
endinterface

interface imm_out_if import imm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [PROD_W-1:0] product;
  logic                     last;
  status_t                  status;

  modport source(output valid, output row, output col, output product, output last,
                 output status, input ready);
  modport sink(input valid, input row, input col, input product, input last,
               input status, output ready);
endinterface

/* design/imm_mac.sv */
// Shared multiply-accumulate unit: registered product, then a 36-bit accumulator.
module imm_mac import imm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mac_ctl_t                     ctl,
  input  logic signed [ELEM_WIDTH-1:0] a_data,
  input  logic signed [ELEM_WIDTH-1:0] b_data,
  output logic signed [PROD_W-1:0]     acc,
  output logic                         done
);

  logic signed [MUL_W-1:0]  prod_r;
  logic                     prod_valid_r;
  logic                     prod_last_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] acc_nxt;

  always_ff @(posedge clk) begin
    prod_r <= a_data * b_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      prod_last_r  <= 1'b0;
    end else begin
      prod_valid_r <= ctl.valid;
      prod_last_r  <= ctl.valid & ctl.last;
    end
  end

  // Sums wrap modulo 2^36.
  always_comb begin
    if (ctl.clear) acc_nxt = '0;
    else if (prod_valid_r) acc_nxt = acc_r + PROD_W'(prod_r);
    else acc_nxt = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc  = acc_r;
  assign done = prod_valid_r & prod_last_r;

endmodule

/* design/integer_matrix_multiply.sv */
// Top level of the integer matrix multiplier: loader, sequencer, stores and result register.
//
// Matrix A (rows_a x cols_a) and matrix B (rows_b x cols_b) are loaded one element per
// input transaction in row-major order; mode selects the target matrix. A transaction
// sent while cols_a differs from rows_b is dropped and answered by one result with status
// mismatch; one sent to a matrix that already holds its full size is dropped and answered
// by one result with status full. The transaction that completes both matrices starts
// the product burst: for each row r and column c the block streams k = 0..cols_a-1
// through the single 16x16 multiplier and accumulator, one operand pair per cycle from
// one read port on each store, then emits the 36-bit sum with row, col and last. Each
// product element passes issue, store read, product register and accumulator before it
// is emitted; an output stall holds the burst, and input ready is low for all of it.
// After the burst both matrices are empty. Dimension registers read 0 as 1 and values
// above 8 as 8. Write them only while the block is idle.
module integer_matrix_multiply import imm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  imm_in_if.sink               in_ch,
  imm_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DIM_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  // Configuration registers
  logic [DIM_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(1);
      cols_a_r <= DIM_W'(1);
      rows_b_r <= DIM_W'(1);
      cols_b_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROWS_A: rows_a_r <= cfg_data;
        REG_COLS_A: cols_a_r <= cfg_data;
        REG_ROWS_B: rows_b_r <= cfg_data;
        REG_COLS_B: cols_b_r <= cfg_data;
        default:    rows_a_r <= rows_a_r;
      endcase
    end
  end

  logic [DIM_W-1:0] ra, ca, rb, cb;
  logic [CNT_W-1:0] size_a, size_b;
  logic [IDX_W-1:0] ra_last, ca_last, cb_last;

  assign ra      = eff_dim(rows_a_r);
  assign ca      = eff_dim(cols_a_r);
  assign rb      = eff_dim(rows_b_r);
  assign cb      = eff_dim(cols_b_r);
  assign size_a  = CNT_W'(ra) * CNT_W'(ca);
  assign size_b  = CNT_W'(rb) * CNT_W'(cb);
  assign ra_last = IDX_W'(ra - DIM_W'(1));
  assign ca_last = IDX_W'(ca - DIM_W'(1));
  assign cb_last = IDX_W'(cb - DIM_W'(1));

  // Sequencer state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_a_r, count_a_nxt, count_b_r, count_b_nxt;
  logic [IDX_W-1:0] r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;

  // Result register
  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [PROD_W-1:0] out_product_r;
  logic                     out_last_r;
  status_t                  out_status_r;

  logic                     out_load;
  logic [IDX_W-1:0]         load_row, load_col;
  logic signed [PROD_W-1:0] load_product;
  logic                     load_last;
  status_t                  load_status;

  logic out_free, in_fire;
  logic mismatch, full_a, full_b, we_a, we_b, run_done;
  logic issue, issue_last, final_elem;
  logic [CNT_W-1:0] next_a, next_b;

  // Multiply-accumulate unit hookup
  mac_ctl_t                     mac_ctl;
  logic signed [PROD_W-1:0]     mac_acc;
  logic                         mac_done;
  logic signed [ELEM_WIDTH-1:0] rd_a_r, rd_b_r;
  logic                         rd_valid_r, rd_last_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign mismatch = (ca != rb);
  assign full_a   = (count_a_r >= size_a);
  assign full_b   = (count_b_r >= size_b);
  assign we_a     = in_fire && !mismatch && (in_ch.mode == MODE_A) && !full_a;
  assign we_b     = in_fire && !mismatch && (in_ch.mode == MODE_B) && !full_b;
  assign next_a   = we_a ? count_a_r + CNT_W'(1) : count_a_r;
  assign next_b   = we_b ? count_b_r + CNT_W'(1) : count_b_r;
  assign run_done = (we_a || we_b) && (next_a >= size_a) && (next_b >= size_b);

  assign issue      = (state_r == S_CALC);
  assign issue_last = (k_r == ca_last);
  assign final_elem = (r_r == ra_last) && (c_r == cb_last);

  always_comb begin
    state_nxt    = state_r;
    count_a_nxt  = next_a;
    count_b_nxt  = next_b;
    r_nxt        = r_r;
    c_nxt        = c_r;
    k_nxt        = k_r;
    out_load     = 1'b0;
    load_row     = '0;
    load_col     = '0;
    load_product = '0;
    load_last    = 1'b0;
    load_status  = STAT_PRODUCT;
    mac_ctl      = '{valid: rd_valid_r, last: rd_last_r, clear: 1'b0};

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (mismatch) begin
            out_load    = 1'b1;
            load_status = STAT_MISMATCH;
          end else if ((in_ch.mode == MODE_A && full_a) ||
                       (in_ch.mode == MODE_B && full_b)) begin
            out_load    = 1'b1;
            load_status = STAT_FULL;
          end else if (run_done) begin
            state_nxt = S_CALC;
            r_nxt     = '0;
            c_nxt     = '0;
            k_nxt     = '0;
          end
        end
      end
      S_CALC: begin
        // Issue one operand pair per cycle along k.
        if (issue_last) begin
          k_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (mac_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          load_row      = r_r;
          load_col      = c_r;
          load_product  = mac_acc;
          load_last     = final_elem;
          load_status   = STAT_PRODUCT;
          mac_ctl.clear = 1'b1;
          if (final_elem) begin
            count_a_nxt = '0;
            count_b_nxt = '0;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_CALC;
            if (c_r == cb_last) begin
              c_nxt = '0;
              r_nxt = r_r + IDX_W'(1);
            end else begin
              c_nxt = c_r + IDX_W'(1);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_a_r  <= '0;
      count_b_r  <= '0;
      r_r        <= '0;
      c_r        <= '0;
      k_r        <= '0;
      rd_valid_r <= 1'b0;
      rd_last_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_a_r  <= count_a_nxt;
      count_b_r  <= count_b_nxt;
      r_r        <= r_nxt;
      c_r        <= c_nxt;
      k_r        <= k_nxt;
      rd_valid_r <= issue;
      rd_last_r  <= issue && issue_last;
    end
  end

  // Element stores: one write port (load), one registered read port (burst).
  logic [CNT_W-1:0]  addr_a_full, addr_b_full;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;

  assign addr_a_full = CNT_W'(r_r) * CNT_W'(ca) + CNT_W'(k_r);
  assign addr_b_full = CNT_W'(k_r) * CNT_W'(cb) + CNT_W'(c_r);
  assign rd_addr_a   = addr_a_full[ADDR_W-1:0];
  assign rd_addr_b   = addr_b_full[ADDR_W-1:0];

  logic signed [ELEM_WIDTH-1:0] store_a [DEPTH];
  logic signed [ELEM_WIDTH-1:0] store_b [DEPTH];

  always_ff @(posedge clk) begin
    if (we_a) store_a[count_a_r[ADDR_W-1:0]] <= in_ch.element;
    rd_a_r <= store_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) store_b[count_b_r[ADDR_W-1:0]] <= in_ch.element;
    rd_b_r <= store_b[rd_addr_b];
  end

  imm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a_data (rd_a_r),
    .b_data (rd_b_r),
    .acc    (mac_acc),
    .done   (mac_done)
  );

  // Result register: load on a new result, drop once the sink takes it.
  always_comb begin
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r     <= load_row;
      out_col_r     <= load_col;
      out_product_r <= load_product;
      out_last_r    <= load_last;
      out_status_r  <= load_status;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.row     = out_row_r;
  assign out_ch.col     = out_col_r;
  assign out_ch.product = out_product_r;
  assign out_ch.last    = out_last_r;
  assign out_ch.status  = out_status_r;

endmodule

/* design/imm_checker.sv */
// Port-level assertions for the integer matrix multiplier, bound to the top level.
module imm_checker import imm_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [IDX_W-1:0]         out_row,
  input logic [IDX_W-1:0]         out_col,
  input logic signed [PROD_W-1:0] out_product,
  input logic                     out_last,
  input status_t                  out_status
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_product) && $stable(out_status) &&
                                $stable(out_last))
    else $error("result payload changed while stalled");

  // Status results carry all-zero fields.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_PRODUCT |->
      out_product == '0 && !out_last && out_row == '0 && out_col == '0)
    else $error("status result with nonzero fields");

  // No new transaction is taken while a result waits for a stalled sink.
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result slot is blocked");

  // Only product results mark the end of a burst; a status result never does.
  a_last_product: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_status == STAT_PRODUCT)
    else $error("last marker on a status result");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_row     (out_ch.row),
  .out_col     (out_ch.col),
  .out_product (out_ch.product),
  .out_last    (out_ch.last),
  .out_status  (out_ch.status)
);
